/* rtl/core/ttl_cache_with_replacement_macros.svh */
// Assertion macros for the expiring cache.
`ifndef TTL_CACHE_WITH_REPLACEMENT_MACROS_SVH
`define TTL_CACHE_WITH_REPLACEMENT_MACROS_SVH

// checked outside reset
`define TTLC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ttlc check failed");

// checked during reset as well
`define TTLC_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("ttlc reset check failed");

`endif

/* rtl/core/ttlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_pkg
// Shared constants and types of the expiring cache.
// ----------------------------------------------------------------------------
package ttlc_pkg;
  localparam int ENTRIES  = 64;
  localparam int MAX_HITS = 5;
  localparam int IDX_W    = $clog2(ENTRIES);
  localparam int CNT_W    = $clog2(MAX_HITS + 1);
  localparam int KEY_W    = 32;
  localparam int ADDR_W   = 32;
  localparam int TIME_W   = 31;
  localparam int LIFE_W   = 16;
  localparam int SLOT_W   = 6;
  localparam logic [LIFE_W-1:0] LIFE_RST = LIFE_W'(10);
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] expiry;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;
endpackage

/* rtl/core/ttlc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_cell
// One cache entry; passes its contents to the neighbor when the ring turns.
// ----------------------------------------------------------------------------
module ttlc_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  logic            wr_en,
  input  ttlc_pkg::entry_t din,
  input  ttlc_pkg::entry_t wr_data,
  output ttlc_pkg::entry_t q
);
  logic valid_r;
  logic [ttlc_pkg::KEY_W-1:0]  key_r;
  logic [ttlc_pkg::ADDR_W-1:0] addr_r;
  logic [ttlc_pkg::TIME_W-1:0] exp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_en) begin
      valid_r <= wr_data.valid;
    end else if (shift_en) begin
      valid_r <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_r  <= wr_data.key;
      addr_r <= wr_data.addr;
      exp_r  <= wr_data.expiry;
    end else if (shift_en) begin
      key_r  <= din.key;
      addr_r <= din.addr;
      exp_r  <= din.expiry;
    end
  end

  assign q = '{valid: valid_r, key: key_r, addr: addr_r, expiry: exp_r};
endmodule

/* rtl/core/ttl_cache_with_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttl_cache_with_replacement
// Expiring key to address cache built as a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// The final result follows a scan of every entry and waits while the result side
// stalls. A new word is accepted only once the previous one is finished; the ring
// turns once per item, one entry per cycle unless a hit waits on the result side.
// Reset: synchronous, active low; cache empty, lifetime 10, no result held.
module ttl_cache_with_replacement (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [31:0] in_name_key,
  input  logic [31:0] in_ipv4_address,
  input  logic [30:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic [5:0]  out_slot,
  output logic [31:0] out_found_address,
  output logic        out_last
);
  localparam int N  = ttlc_pkg::ENTRIES;
  localparam int IW = ttlc_pkg::IDX_W;
  localparam int CW = ttlc_pkg::CNT_W;
  localparam int TW = ttlc_pkg::TIME_W;

  ttlc_pkg::state_t state_r;
  logic [ttlc_pkg::LIFE_W-1:0] life_r;
  logic        op_r;
  logic [31:0] key_r, addr_r;
  logic [TW-1:0] now_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] cnt_r;
  logic          pend_v_r;
  logic [IW-1:0] pend_idx_r;
  logic [31:0]   pend_addr_r;
  logic          expf_r, empf_r, earf_r;
  logic [IW-1:0] exp_pos_r, emp_pos_r, ear_pos_r;
  logic [TW-1:0] ear_val_r;
  logic          ov_r, oh_r, ol_r;
  logic [IW-1:0] oi_r;
  logic [31:0]   oa_r;

  ttlc_pkg::entry_t cell_q [N];
  ttlc_pkg::entry_t head, wr_ent;
  logic out_free, expired, take, stall, advance, fin_push, fin_wr, out_push;
  logic [IW-1:0] pos;
  logic [TW:0]   sum;
  logic [IW+5:0] slot_ext;

  assign head     = cell_q[0];
  assign out_free = !ov_r || out_ready;
  assign expired  = (head.expiry != '0) && (now_r > head.expiry);
  assign take     = (op_r == ttlc_pkg::OP_LOOKUP) && head.valid && (head.key == key_r)
                    && !expired && (cnt_r < CW'(ttlc_pkg::MAX_HITS));
  assign stall    = take && pend_v_r && !out_free;
  assign advance  = (state_r == ttlc_pkg::ST_SCAN) && !stall;
  assign fin_push = (state_r == ttlc_pkg::ST_FIN) && out_free;
  assign fin_wr   = fin_push && (op_r == ttlc_pkg::OP_INSERT);
  assign out_push = (advance && take && pend_v_r) || fin_push;
  assign in_ready = (state_r == ttlc_pkg::ST_IDLE);

  assign pos = expf_r ? exp_pos_r : empf_r ? emp_pos_r : earf_r ? ear_pos_r : '0;
  assign sum = {1'b0, now_r} + (TW+1)'(life_r);
  assign wr_ent = '{valid: 1'b1, key: key_r, addr: addr_r,
                    expiry: sum[TW] ? {TW{1'b1}} : sum[TW-1:0]};

  for (genvar i = 0; i < N; i++) begin : g_cell
    ttlc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (advance),
      .wr_en    (fin_wr && (pos == IW'(i))),
      .din      (cell_q[(i + 1) % N]),
      .wr_data  (wr_ent),
      .q        (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      life_r <= ttlc_pkg::LIFE_RST;
    end else if (cfg_we) begin
      life_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ttlc_pkg::ST_IDLE;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (out_push) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      case (state_r)
        ttlc_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_r     <= in_operation;
            key_r    <= in_name_key;
            addr_r   <= in_ipv4_address;
            now_r    <= in_now_seconds;
            idx_r    <= '0;
            cnt_r    <= '0;
            pend_v_r <= 1'b0;
            expf_r   <= 1'b0;
            empf_r   <= 1'b0;
            earf_r   <= 1'b0;
            state_r  <= ttlc_pkg::ST_SCAN;
          end
        end
        ttlc_pkg::ST_SCAN: begin
          if (advance) begin
            if (take) begin
              if (pend_v_r) begin
                oh_r <= 1'b1; ol_r <= 1'b0;
                oi_r <= pend_idx_r; oa_r <= pend_addr_r;
              end
              pend_v_r    <= 1'b1;
              pend_idx_r  <= idx_r;
              pend_addr_r <= head.addr;
              cnt_r       <= cnt_r + CW'(1);
            end
            if (op_r == ttlc_pkg::OP_INSERT && !expf_r) begin
              if (!head.valid) begin
                if (!empf_r) begin
                  empf_r <= 1'b1; emp_pos_r <= idx_r;
                end
              end else if (expired) begin
                expf_r <= 1'b1; exp_pos_r <= idx_r;
              end else if (!earf_r || head.expiry <= ear_val_r) begin
                earf_r <= 1'b1; ear_pos_r <= idx_r; ear_val_r <= head.expiry;
              end
            end
            idx_r <= idx_r + IW'(1);
            if (idx_r == IW'(N - 1)) state_r <= ttlc_pkg::ST_FIN;
          end
        end
        ttlc_pkg::ST_FIN: begin
          if (fin_push) begin
            ol_r <= 1'b1;
            if (op_r == ttlc_pkg::OP_INSERT) begin
              oh_r <= 1'b0; oi_r <= pos; oa_r <= '0;
            end else if (pend_v_r) begin
              oh_r <= 1'b1; oi_r <= pend_idx_r; oa_r <= pend_addr_r;
            end else begin
              oh_r <= 1'b0; oi_r <= '0; oa_r <= '0;
            end
            pend_v_r <= 1'b0;
            state_r  <= ttlc_pkg::ST_IDLE;
          end
        end
        default: state_r <= ttlc_pkg::ST_IDLE;
      endcase
    end
  end

  assign slot_ext          = {6'b0, oi_r};
  assign out_valid         = ov_r;
  assign out_hit           = oh_r;
  assign out_slot          = slot_ext[5:0];
  assign out_found_address = oa_r;
  assign out_last          = ol_r;
endmodule

/* rtl/core/ttlc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttlc_checker
// Port-level checks of the expiring cache, bound to the top level.
// ----------------------------------------------------------------------------
`include "ttl_cache_with_replacement_macros.svh"
module ttlc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [5:0]  out_slot,
  input logic [31:0] out_found_address
);
  `TTLC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)
  `TTLC_ASSERT(a_slot_hold, out_valid && !out_ready |=> $stable(out_slot))
  `TTLC_ASSERT(a_one_word, in_valid && in_ready |=> !in_ready)
  `TTLC_ASSERT(a_miss_zero, out_valid && !out_hit |-> out_found_address == 32'd0)
  `TTLC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid)
endmodule

bind ttl_cache_with_replacement ttlc_checker u_ttlc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_hit           (out_hit),
  .out_slot          (out_slot),
  .out_found_address (out_found_address)
);
